/* hdl/sorted_timer_expiry_queue_macros.svh */
// ----------------------------------------------------------------------------
// Sorted timer expiry queue assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH

// same-cycle implication
`define STEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("steq assertion failed");

// next-cycle implication
`define STEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("steq assertion failed");

`endif

/* hdl/steq_pkg.sv */
// ----------------------------------------------------------------------------
// steq_pkg
// Constants, beat types and controller/datapath interface for the timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package steq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_BITS  = 32;
    localparam int ID_BITS    = 4;
    localparam int CNT_BITS   = 5;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ID_BITS-1:0]   timer_id;
        logic [TICK_BITS-1:0] tick_value;
    } req_beat_t;

    typedef struct packed {
        logic                 kind;
        logic [ID_BITS-1:0]   expired_id;
        logic [TICK_BITS-1:0] compare_value;
        logic [TICK_BITS-1:0] earliest;
        logic                 last;
    } rsp_beat_t;

    typedef struct packed {
        logic load_req;
        logic ptr_clr;
        logic ptr_inc;
        logic do_insert;
        logic do_remove;
        logic do_pop;
        logic emit_exp;
        logic emit_cmp;
    } steq_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_stop;
        logic is_check;
        logic start_ok;
        logic stop_ok;
        logic scan_hit;
        logic ptr_end;
        logic ptr_zero;
        logic head_due;
        logic out_free;
    } steq_sts_t;

endpackage

`default_nettype wire

/* hdl/steq_ctrl.sv */
// ----------------------------------------------------------------------------
// steq_ctrl
// Sequencer for start, stop and check requests of the timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

module steq_ctrl
    import steq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire steq_sts_t sts,
    output steq_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       popped_reg, popped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            popped_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            popped_reg <= popped_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        popped_next = popped_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                popped_next = 1'b0;
                cmd.ptr_clr = 1'b1;
                priority if ((sts.is_start && sts.start_ok) || (sts.is_stop && sts.stop_ok))
                    state_next = ST_SCAN;
                else if (sts.is_check)
                    state_next = ST_POP;
                else
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.ptr_end || sts.scan_hit)
                    state_next = ST_APPLY;
                else
                    cmd.ptr_inc = 1'b1;
            end
            ST_APPLY:
            begin
                cmd.do_insert = sts.is_start;
                cmd.do_remove = sts.is_stop;
                state_next    = sts.ptr_zero ? ST_EMIT : ST_IDLE;
            end
            ST_POP:
            begin
                priority if (sts.head_due)
                begin
                    if (sts.out_free)
                    begin
                        cmd.do_pop   = 1'b1;
                        cmd.emit_exp = 1'b1;
                        popped_next  = 1'b1;
                    end
                end
                else if (popped_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_cmp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/steq_datapath.sv */
// ----------------------------------------------------------------------------
// steq_datapath
// Ordered slot array, queued flags, scan pointer and response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_timer_expiry_queue_macros.svh"

module steq_datapath
    import steq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_beat_t req,
    input  wire logic      rsp_stall,
    output logic           rsp_valid,
    output rsp_beat_t      rsp,
    input  wire steq_cmd_t cmd,
    output steq_sts_t      sts
);

    req_beat_t            req_reg;
    req_beat_t            req_in;
    logic [ID_BITS-1:0]   slot_id_reg  [NUM_TIMERS];
    logic [TICK_BITS-1:0] slot_exp_reg [NUM_TIMERS];
    logic [ID_BITS-1:0]   slot_id_next [NUM_TIMERS];
    logic [TICK_BITS-1:0] slot_exp_next[NUM_TIMERS];
    logic [NUM_TIMERS-1:0] queued_reg, queued_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  ptr_reg, ptr_next;
    rsp_beat_t            rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [ID_BITS-1:0]   pidx;
    logic [ID_BITS-1:0]   sel_id;
    logic [TICK_BITS-1:0] sel_exp;
    logic [TICK_BITS-1:0] head_now;
    logic [TICK_BITS-1:0] head_after_pop;
    logic                 id_ok;
    logic                 out_free;

    assign pidx     = ptr_reg[ID_BITS-1:0];
    assign sel_id   = slot_id_reg[pidx];
    assign sel_exp  = slot_exp_reg[pidx];
    assign head_now = (count_reg != '0) ? slot_exp_reg[0] : '0;
    assign head_after_pop = (count_reg > CNT_BITS'(1)) ? slot_exp_reg[1] : '0;
    assign id_ok    = ({1'b0, req_reg.timer_id} < CNT_BITS'(NUM_TIMERS));
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        sts.is_start = (req_reg.mode == MODE_START);
        sts.is_stop  = (req_reg.mode == MODE_STOP);
        sts.is_check = (req_reg.mode == MODE_CHECK);
        sts.start_ok = id_ok && !queued_reg[req_reg.timer_id]
                       && (count_reg < CNT_BITS'(NUM_TIMERS));
        sts.stop_ok  = id_ok && queued_reg[req_reg.timer_id];
        sts.scan_hit = (req_reg.mode == MODE_START) ? (sel_exp > req_reg.tick_value)
                                                    : (sel_id == req_reg.timer_id);
        sts.ptr_end  = (ptr_reg == count_reg);
        sts.ptr_zero = (ptr_reg == '0);
        sts.head_due = (count_reg != '0) && (req_reg.tick_value >= slot_exp_reg[0]);
        sts.out_free = out_free;
    end

    always_comb
    begin
        req_in = req;
        if ((req.mode == MODE_START) && (req.tick_value == '0))
            req_in.tick_value = TICK_BITS'(1);
    end

    always_comb
    begin
        slot_id_next  = slot_id_reg;
        slot_exp_next = slot_exp_reg;
        queued_next   = queued_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        if (cmd.ptr_clr)
            ptr_next = '0;
        else if (cmd.ptr_inc)
            ptr_next = ptr_reg + CNT_BITS'(1);
        if (cmd.do_insert)
        begin
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                if (CNT_BITS'(k) == ptr_reg)
                begin
                    slot_id_next[k]  = req_reg.timer_id;
                    slot_exp_next[k] = req_reg.tick_value;
                end
                else if ((k > 0) && (CNT_BITS'(k) > ptr_reg))
                begin
                    slot_id_next[k]  = slot_id_reg[(k > 0) ? k - 1 : 0];
                    slot_exp_next[k] = slot_exp_reg[(k > 0) ? k - 1 : 0];
                end
            end
            queued_next[req_reg.timer_id] = 1'b1;
            count_next = count_reg + CNT_BITS'(1);
        end
        if (cmd.do_remove || cmd.do_pop)
        begin
            for (int k = 0; k < NUM_TIMERS - 1; k++)
            begin
                if (cmd.do_pop || (CNT_BITS'(k) >= ptr_reg))
                begin
                    slot_id_next[k]  = slot_id_reg[k + 1];
                    slot_exp_next[k] = slot_exp_reg[k + 1];
                end
            end
            if (cmd.do_pop)
                queued_next[slot_id_reg[0]] = 1'b0;
            else
                queued_next[req_reg.timer_id] = 1'b0;
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.emit_exp)
        begin
            rsp_next.kind          = KIND_EXPIRED;
            rsp_next.expired_id    = slot_id_reg[0];
            rsp_next.compare_value = '0;
            rsp_next.earliest      = head_after_pop;
            rsp_next.last          = 1'b0;
            rsp_valid_next         = 1'b1;
        end
        else if (cmd.emit_cmp)
        begin
            rsp_next.kind          = KIND_COMPARE;
            rsp_next.expired_id    = '0;
            rsp_next.compare_value = head_now;
            rsp_next.earliest      = head_now;
            rsp_next.last          = 1'b1;
            rsp_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg    <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            queued_reg    <= queued_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req_in;
        slot_id_reg  <= slot_id_next;
        slot_exp_reg <= slot_exp_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `STEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(NUM_TIMERS))
    `STEQ_ASSERT_NOW(a_flags_match, 1'b1, $countones(queued_reg) == 32'(count_reg))
    `STEQ_ASSERT_NEXT(a_pop_shrinks, cmd.do_pop, count_reg == $past(count_reg) - CNT_BITS'(1))
    `STEQ_ASSERT_NOW(a_emit_room, cmd.emit_exp || cmd.emit_cmp, out_free)

endmodule

`default_nettype wire

/* hdl/sorted_timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Timer queue kept in expiry order, reporting expirations and compare updates.
// ----------------------------------------------------------------------------
// One request is in work at a time; req_stall is high from the accepting edge
// until it is finished. A start or stop request that is ignored goes from the
// decode state straight back to idle. One that is carried out also passes
// through the scan and apply states (the insert position or the stopped timer
// is found by a pointer walking the ordered slot array one entry per cycle);
// one that changes the head then sends a compare beat. A check pops every
// expired timer, then sends a compare beat if any expired; each expiry leaves
// through the single response register as its own beat. A response stall
// holds each of these beats until the response register is free.
`default_nettype none

module sorted_timer_expiry_queue
    import steq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_beat_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_beat_t      rsp
);

    steq_cmd_t cmd;
    steq_sts_t sts;

    steq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    steq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
